### hw/rtl/fscan_pkg.sv
`timescale 1ns / 1ps
package fscan_pkg;

  localparam int ID_BITS = 16;
  localparam int FIELD_BITS = 16;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_DISP = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_SHIFT = 2'd2,
    S_OUT = 2'd3
  } state_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

endpackage

### hw/rtl/fscan_if.sv
`timescale 1ns / 1ps
interface fscan_in_if;
  import fscan_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  logic [ID_BITS-1:0] request_id;
  logic [FIELD_BITS-1:0] track;
  logic [FIELD_BITS-1:0] head_track;
  modport source (output valid, mode, request_id, track, head_track, input ready);
  modport sink (input valid, mode, request_id, track, head_track, output ready);
endinterface

interface fscan_out_if;
  import fscan_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [ID_BITS-1:0] out_id;
  logic [FIELD_BITS-1:0] out_track;
  logic moving_up;
  modport source (output valid, status, out_id, out_track, moving_up, input ready);
  modport sink (input valid, status, out_id, out_track, moving_up, output ready);
endinterface

### hw/rtl/fscan_disk_scheduler_top.sv
`timescale 1ns / 1ps
// the scan covers at most the entries of the queue being worked on; a full add and an
// empty dispatch scan none
// the scan steps one cell per cycle through the queue; insert/remove shift the whole
// chain of cells at once, and the result is registered with the shift
// one item at a time: a new input is accepted only after the last result is taken
// reset: synchronous, both queues empty, store b active, sweep upward; no clearing pass
module fscan_disk_scheduler_top import fscan_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TRACK_BITS = 16
) (
  input logic clk,
  input logic rst,
  fscan_in_if.sink in_ch,
  fscan_out_if.source out_ch
);

  localparam int PB = $clog2(QUEUE_DEPTH);
  localparam int CB = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic [CB-1:0] count_a, count_b;
  logic active_is_b, sweep_up;

  logic is_disp;
  logic [ID_BITS-1:0] req_id;
  logic [TRACK_BITS-1:0] req_trk, head;
  logic [CB-1:0] idx;
  logic [CB-1:0] scan_n;
  logic sel_b;

  logic found, exact, have_lo, have_hi;
  logic [PB-1:0] ins_pos, ex_pos, lo_pos, hi_pos, pick;
  logic [TRACK_BITS-1:0] lo_dist, hi_dist;

  logic [1:0] o_status;
  logic [ID_BITS-1:0] o_id;
  logic [FIELD_BITS-1:0] o_trk;

  cmd_t cmd;
  logic [PB-1:0] cmd_pos;

  logic [ID_BITS-1:0] c_id [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0] c_trk [QUEUE_DEPTH];

  // chain of cells
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] lid, rid;
    logic [TRACK_BITS-1:0] ltk, rtk;
    if (g == 0) begin : g_l0
      assign lid = '0; assign ltk = '0;
    end else begin : g_ln
      assign lid = c_id[g-1]; assign ltk = c_trk[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_rl
      assign rid = '0; assign rtk = '0;
    end else begin : g_rn
      assign rid = c_id[g+1]; assign rtk = c_trk[g+1];
    end
    fscan_cell #(.TB(TRACK_BITS), .POS_BITS(PB), .MY_POS(g)) u_cell (
      .clk(clk), .cmd(cmd), .sel_b(sel_b), .pos(cmd_pos),
      .new_id(req_id), .new_trk(req_trk),
      .left_id(lid), .left_trk(ltk), .right_id(rid), .right_trk(rtk),
      .id(c_id[g]), .trk(c_trk[g])
    );
  end

  // store being worked on: waiting for add, active for dispatch
  assign sel_b = is_disp ? active_is_b : !active_is_b;

  logic [TRACK_BITS-1:0] cur_trk;
  logic [PB-1:0] idx_p;
  assign idx_p = idx[PB-1:0];
  assign cur_trk = c_trk[idx_p];

  logic [TRACK_BITS-1:0] d_lo, d_hi;
  assign d_lo = head - cur_trk;
  assign d_hi = cur_trk - head;

  // pick after scan
  always_comb begin
    if (exact) pick = ex_pos;
    else if (sweep_up) pick = have_hi ? hi_pos : lo_pos;
    else pick = have_lo ? lo_pos : hi_pos;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid) state_next = S_SCAN;
      S_SCAN: if (idx >= scan_n || found || exact || o_status == ST_DROPPED)
        state_next = S_SHIFT;
      S_SHIFT: state_next = S_OUT;
      S_OUT: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and cell command
  always_comb begin
    in_ch.ready = (state == S_IDLE);
    out_ch.valid = (state == S_OUT);
    out_ch.status = o_status;
    out_ch.out_id = o_id;
    out_ch.out_track = o_trk;
    out_ch.moving_up = sweep_up;
    cmd = CMD_HOLD;
    cmd_pos = '0;
    if (state == S_SHIFT && o_status == ST_ADDED) begin
      cmd = CMD_INSERT; cmd_pos = ins_pos;
    end else if (state == S_SHIFT && o_status == ST_DISPATCHED) begin
      cmd = CMD_REMOVE; cmd_pos = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count_a <= '0;
      count_b <= '0;
      active_is_b <= 1'b1;
      sweep_up <= 1'b1;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            is_disp <= (in_ch.mode == MODE_DISP);
            req_id <= in_ch.request_id;
            req_trk <= in_ch.track[TRACK_BITS-1:0];
            head <= in_ch.head_track[TRACK_BITS-1:0];
            idx <= '0;
            found <= 1'b0; exact <= 1'b0; have_lo <= 1'b0; have_hi <= 1'b0;
            o_id <= '0; o_trk <= '0;
            if (in_ch.mode == MODE_ADD) begin
              scan_n <= active_is_b ? count_a : count_b;
              ins_pos <= PB'(active_is_b ? count_a : count_b);
              o_status <= ((active_is_b ? count_a : count_b) >= CB'(QUEUE_DEPTH))
                          ? ST_DROPPED : ST_ADDED;
            end else if (count_a == '0 && count_b == '0) begin
              scan_n <= '0;
              o_status <= ST_EMPTY;
            end else begin
              o_status <= ST_DISPATCHED;
              if ((active_is_b ? count_b : count_a) == '0) begin
                active_is_b <= !active_is_b;
                sweep_up <= 1'b1;
                scan_n <= active_is_b ? count_a : count_b;
              end else begin
                scan_n <= active_is_b ? count_b : count_a;
              end
            end
          end
        end
        S_SCAN: begin
          // one cell per cycle
          if (!(idx >= scan_n || found || exact) && o_status != ST_DROPPED
              && o_status != ST_EMPTY) begin
            idx <= idx + 1'b1;
            if (!is_disp) begin
              if (req_trk < cur_trk) begin
                found <= 1'b1; ins_pos <= idx_p;
              end
            end else if (cur_trk == head) begin
              exact <= 1'b1; ex_pos <= idx_p;
            end else if (cur_trk < head) begin
              if (!have_lo || d_lo < lo_dist) begin
                have_lo <= 1'b1; lo_dist <= d_lo; lo_pos <= idx_p;
              end
            end else begin
              if (!have_hi || d_hi < hi_dist) begin
                have_hi <= 1'b1; hi_dist <= d_hi; hi_pos <= idx_p;
              end
            end
          end
        end
        S_SHIFT: begin
          if (o_status == ST_ADDED) begin
            if (active_is_b) count_a <= count_a + 1'b1;
            else count_b <= count_b + 1'b1;
          end else if (o_status == ST_DISPATCHED) begin
            o_id <= c_id[pick];
            o_trk <= FIELD_BITS'(c_trk[pick]);
            if (active_is_b) count_b <= count_b - 1'b1;
            else count_a <= count_a - 1'b1;
            if (!exact) begin
              if (sweep_up && !have_hi) sweep_up <= 1'b0;
              else if (!sweep_up && !have_lo) sweep_up <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_cnt_a: assert property (@(posedge clk) disable iff (rst)
    count_a <= CB'(QUEUE_DEPTH)) else $error("count_a overflow");
  a_cnt_b: assert property (@(posedge clk) disable iff (rst)
    count_b <= CB'(QUEUE_DEPTH)) else $error("count_b overflow");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_DISPATCHED |-> out_ch.out_id == '0)
    else $error("nonzero id without dispatch");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");

endmodule

### hw/rtl/fscan_cell.sv
`timescale 1ns / 1ps
// one queue slot: holds (id, track) for both queues, shifts with neighbors
module fscan_cell import fscan_pkg::*; #(
  parameter int TB = 16,
  parameter int POS_BITS = 5,
  parameter int MY_POS = 0
) (
  input  logic clk,
  input  cmd_t cmd,
  input  logic sel_b,
  input  logic [POS_BITS-1:0] pos,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [TB-1:0] new_trk,
  input  logic [ID_BITS-1:0] left_id,
  input  logic [TB-1:0] left_trk,
  input  logic [ID_BITS-1:0] right_id,
  input  logic [TB-1:0] right_trk,
  output logic [ID_BITS-1:0] id,
  output logic [TB-1:0] trk
);

  logic [ID_BITS-1:0] id_a, id_b;
  logic [TB-1:0] trk_a, trk_b;
  logic [ID_BITS-1:0] id_n;
  logic [TB-1:0] trk_n;
  logic [POS_BITS-1:0] me;
  logic upd;

  assign me = POS_BITS'(MY_POS);
  assign id = sel_b ? id_b : id_a;
  assign trk = sel_b ? trk_b : trk_a;

  // next contents of the selected queue slot
  always_comb begin
    id_n = id;
    trk_n = trk;
    upd = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (me == pos) begin
          id_n = new_id; trk_n = new_trk; upd = 1'b1;
        end else if (me > pos) begin
          id_n = left_id; trk_n = left_trk; upd = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (me >= pos) begin
          id_n = right_id; trk_n = right_trk; upd = 1'b1;
        end
      end
      default: upd = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      if (sel_b) begin
        id_b <= id_n; trk_b <= trk_n;
      end else begin
        id_a <= id_n; trk_a <= trk_n;
      end
    end
  end

endmodule

### verif/fscan_disk_scheduler_top_tb.sv
`timescale 1ns / 1ps
module fscan_disk_scheduler_top_tb;
  import fscan_pkg::*;

  localparam int DEPTH = 32;
  localparam int LIMIT = 400000;

  typedef struct packed {
    status_t st;
    logic [15:0] id;
    logic [15:0] trk;
    logic up;
  } sched_res_t;

  typedef struct {
    mode_t mode;
    logic [15:0] id;
    logic [15:0] trk;
    logic [15:0] head;
    logic has_res;
    sched_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  fscan_in_if in_ch();
  fscan_out_if out_ch();

  fscan_disk_scheduler_top DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  // predictor state
  logic [15:0] q_id [2][DEPTH];
  logic [15:0] q_trk [2][DEPTH];
  int q_cnt [2];
  int act_q;
  logic sweep;

  sched_res_t pending_q[$];
  int errors = 0;
  int n_mis = 0;
  int cycles = 0;
  int hold_off = 0;
  logic in_pause = 1'b0;

  task automatic sched_reset();
    q_cnt[0] = 0;
    q_cnt[1] = 0;
    act_q = 1;
    sweep = 1'b1;
  endtask

  function automatic sched_res_t sched_step(mode_t m, logic [15:0] id, logic [15:0] trk,
                                            logic [15:0] head);
    sched_res_t r;
    int w, n, pos, pick, lo_pos, hi_pos;
    int lo_d, hi_d, d;
    bit exact, have_lo, have_hi;
    r = '{st: ST_ADDED, id: 16'd0, trk: 16'd0, up: 1'b0};
    exact = 0; have_lo = 0; have_hi = 0;
    lo_pos = 0; hi_pos = 0; lo_d = 0; hi_d = 0; pick = 0;
    if (m == MODE_ADD) begin
      w = 1 - act_q;
      n = q_cnt[w];
      if (n >= DEPTH) r.st = ST_DROPPED;
      else begin
        pos = n;
        for (int i = 0; i < n; i++)
          if (trk < q_trk[w][i]) begin pos = i; break; end
        for (int i = n; i > pos; i--) begin
          q_id[w][i] = q_id[w][i-1];
          q_trk[w][i] = q_trk[w][i-1];
        end
        q_id[w][pos] = id;
        q_trk[w][pos] = trk;
        q_cnt[w] = n + 1;
      end
    end else if (q_cnt[0] == 0 && q_cnt[1] == 0) begin
      r.st = ST_EMPTY;
    end else begin
      if (q_cnt[act_q] == 0) begin
        act_q = 1 - act_q;
        sweep = 1'b1;
      end
      n = q_cnt[act_q];
      // nearest entry on each side, exact hit wins outright
      for (int i = 0; i < n; i++) begin
        if (q_trk[act_q][i] == head) begin exact = 1; pick = i; break; end
        if (q_trk[act_q][i] < head) begin
          d = head - q_trk[act_q][i];
          if (!have_lo || d < lo_d) begin have_lo = 1; lo_d = d; lo_pos = i; end
        end else begin
          d = q_trk[act_q][i] - head;
          if (!have_hi || d < hi_d) begin have_hi = 1; hi_d = d; hi_pos = i; end
        end
      end
      if (!exact) begin
        if (sweep) begin
          if (have_hi) pick = hi_pos;
          else begin pick = lo_pos; sweep = 1'b0; end
        end else begin
          if (have_lo) pick = lo_pos;
          else begin pick = hi_pos; sweep = 1'b1; end
        end
      end
      r.st = ST_DISPATCHED;
      r.id = q_id[act_q][pick];
      r.trk = q_trk[act_q][pick];
      for (int i = pick; i + 1 < n; i++) begin
        q_id[act_q][i] = q_id[act_q][i+1];
        q_trk[act_q][i] = q_trk[act_q][i+1];
      end
      q_cnt[act_q] = n - 1;
    end
    r.up = sweep;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one item, wait for acceptance, queue the expectation
  task automatic send_item(mode_t m, logic [15:0] id, logic [15:0] trk, logic [15:0] head,
                           logic has_res, sched_res_t fixed);
    sched_res_t r;
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.request_id <= id;
    in_ch.track <= trk;
    in_ch.head_track <= head;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = sched_step(m, id, trk, head);
    pending_q.push_back(has_res ? fixed : r);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** fscan_disk_scheduler_top: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, occasional long hold-off
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    sched_res_t exp_r;
    sched_res_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{st: status_t'(out_ch.status), id: out_ch.out_id, trk: out_ch.out_track,
              up: out_ch.moving_up};
      if (pending_q.size() == 0) begin
        errors++;
        if (n_mis < 10) $display("unexpected result %p", got);
        n_mis++;
      end else begin
        exp_r = pending_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (n_mis < 10) $display("mismatch: expected %p got %p", exp_r, got);
          n_mis++;
        end
      end
    end
  end

  stim_row_t dir_tbl[$];

  task automatic add_row(mode_t m, logic [15:0] id, logic [15:0] trk, logic [15:0] head,
                         logic has, sched_res_t r);
    dir_tbl.push_back('{m, id, trk, head, has, r});
  endtask

  initial begin
    sched_res_t none;
    mode_t m;
    logic [15:0] base;
    int k;
    none = '{st: ST_ADDED, id: 16'd0, trk: 16'd0, up: 1'b0};
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ADD;
    in_ch.request_id = '0;
    in_ch.track = '0;
    in_ch.head_track = '0;
    sched_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty dispatch, extremes, exact hit, ties, swap
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h1234, 1, '{ST_EMPTY, 16'd0, 16'd0, 1'b1});
    add_row(MODE_ADD, 16'hFFFF, 16'hFFFF, 16'h0000, 1, '{ST_ADDED, 16'd0, 16'd0, 1'b1});
    add_row(MODE_ADD, 16'h0000, 16'h0000, 16'hFFFF, 0, none);
    add_row(MODE_ADD, 16'h00A1, 16'h0100, 16'h0000, 0, none);
    add_row(MODE_ADD, 16'h00A2, 16'h0100, 16'h0000, 0, none);
    add_row(MODE_ADD, 16'h00A3, 16'h0300, 16'h0000, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h0100, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h0200, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'hFFFF, 0, none);
    add_row(MODE_ADD, 16'h0055, 16'h0200, 16'h0000, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h0000, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h0050, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h0000, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h0000, 0, none);
    add_row(MODE_DISP, 16'h0000, 16'h0000, 16'h0000, 0, none);
    foreach (dir_tbl[i])
      send_item(dir_tbl[i].mode, dir_tbl[i].id, dir_tbl[i].trk, dir_tbl[i].head,
                dir_tbl[i].has_res, dir_tbl[i].res);

    // fill waiting queue past full, then drain it, with a long receiver hold-off at the start
    hold_off = 400;
    for (int i = 0; i < DEPTH + 3; i++)
      send_item(MODE_ADD, 16'($urandom), 16'($urandom_range(0, 15)), 16'd0, 0, none);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(MODE_DISP, 16'd0, 16'd0, 16'($urandom_range(0, 15)), 0, none);

    // pause until all results are back
    while (pending_q.size() != 0) @(negedge clk);

    // random: mostly clustered tracks so ties and exact hits are common
    for (k = 0; k < 1000; k++) begin
      m = ($urandom_range(0, 99) < 52) ? MODE_ADD : MODE_DISP;
      base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      send_item(m, 16'($urandom), base,
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                0, none);
      idle_gap(($urandom_range(0, 9) < 7) ? gap_len() : 0);
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(negedge clk);
    repeat (3 * (DEPTH + 3)) @(negedge clk);
    if (errors == 0) $display("** fscan_disk_scheduler_top: PASSED **");
    else $display("** fscan_disk_scheduler_top: FAILED **");
    $finish;
  end

endmodule
